@@ sv/slwsc_pkg.sv @@
// shared types and constants of the single line write-back sector cache
package slwsc_pkg;

	localparam int BLOCK_BYTES = 512;
	localparam int CMD_W = 2;
	localparam int BLK_W = 11;
	localparam int OFF_W = 9;
	localparam int ADDR_W = BLK_W + OFF_W;
	localparam int BC_W = 12;
	localparam int PADDR_W = 2;
	localparam int PDATA_W = 32;

	localparam logic [CMD_W-1:0] CMD_READ = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;

	localparam logic [PADDR_W-1:0] REG_DISK_BLOCKS = 2'd0;
	localparam logic [BC_W-1:0] DISK_BLOCKS_RST = 12'd2048;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [BLK_W-1:0] block_index;
		logic [OFF_W-1:0] byte_offset;
		logic [7:0] write_data;
		logic last_of_request;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic status;
		logic wrote_back;
		logic loaded_sector;
		logic request_done;
	} rsp_t;

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE = 6'b000010,
		S_EXEC = 6'b000100,
		S_WB = 6'b001000,
		S_LOAD = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

endpackage

@@ sv/slwsc_ram.sv @@
// simple dual-port synchronous ram, one write port, one registered read port
module slwsc_ram #(
	parameter int DEPTH = 4096,
	parameter int DW = 8
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [DW-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ sv/single_line_writeback_sector_cache.sv @@
// top level: one-line write-back sector cache with its backing store
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  slwsc_pkg::req_t
//  rsp      out        rsp_valid/rsp_stall  slwsc_pkg::rsp_t
//  apb      in         psel/penable/pready  disk block total at byte address 0
//
// read, write hit, out of range, clean flush: one pass through exec, via done if the response is held
// write-back or sector load: SECTOR_BYTES bytes each, one byte a cycle
// through the store and line ram ports; a dirty write miss does both
// after reset the store is zeroed one byte a cycle with req stalled
// sector and disk sizes must be powers of two; the block itself does not enforce it
// a held response stalls the next one in the done state only
module single_line_writeback_sector_cache #(
	parameter int SECTOR_BYTES = 4096,
	parameter int DISK_BYTES = 1048576
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input slwsc_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output slwsc_pkg::rsp_t rsp,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [slwsc_pkg::PADDR_W-1:0] paddr,
	input logic [slwsc_pkg::PDATA_W-1:0] pwdata,
	output logic [slwsc_pkg::PDATA_W-1:0] prdata,
	output logic pready
);

	localparam int SW = $clog2(SECTOR_BYTES);
	localparam int AW = $clog2(DISK_BYTES);
	localparam int SECW = (AW > SW) ? AW - SW : 1;
	localparam int CW = SW + 1;
	localparam int NBLK = DISK_BYTES / slwsc_pkg::BLOCK_BYTES;

	slwsc_pkg::state_t state_q, state_d;

	logic [slwsc_pkg::BC_W-1:0] disk_blocks_q;
	logic line_valid_q;
	logic line_dirty_q;
	logic [SECW-1:0] line_sector_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] clr_q;

	logic [slwsc_pkg::CMD_W-1:0] cmd_q;
	logic [7:0] wdata_q;
	logic last_q;
	logic [SW-1:0] soff_q;
	logic [SECW-1:0] sec_q;
	logic oor_q;
	logic hit_q;
	slwsc_pkg::rsp_t res_q;

	logic out_valid_q;
	slwsc_pkg::rsp_t out_q;

	// request decode
	logic [slwsc_pkg::ADDR_W-1:0] addr_in;
	logic [SECW-1:0] sec_in;
	logic [SW-1:0] soff_in;
	logic oor_in;
	logic hit_in;
	logic accept;

	// ram ports
	logic ln_we, st_we;
	logic [SW-1:0] ln_waddr, ln_raddr;
	logic [7:0] ln_wdata, ln_rdata;
	logic [AW-1:0] st_waddr, st_raddr;
	logic [7:0] st_wdata, st_rdata;

	logic cnt_last;
	logic [SW-1:0] cnt_idx, cnt_prev;
	logic out_free;
	logic out_load;
	slwsc_pkg::rsp_t out_d;
	slwsc_pkg::rsp_t exec_rsp;
	logic exec_done;
	logic wr_hit;
	logic flush_clean;
	logic cfg_wr;

	assign addr_in = {req.block_index, req.byte_offset};
	assign sec_in = SECW'(addr_in >> SW);
	assign soff_in = SW'(addr_in);
	assign oor_in = ({1'b0, req.block_index} >= disk_blocks_q) ||
		(32'(req.block_index) >= NBLK);
	assign hit_in = line_valid_q && (line_sector_q == sec_in);
	assign accept = req_valid && !req_stall;
	assign req_stall = (state_q != slwsc_pkg::S_IDLE);

	assign cnt_last = (cnt_q == CW'(SECTOR_BYTES));
	assign cnt_idx = cnt_q[SW-1:0];
	assign cnt_prev = SW'(cnt_q - 1'b1);
	assign out_free = !out_valid_q || !rsp_stall;

	assign cfg_wr = psel && penable && pwrite && pready &&
		(paddr == slwsc_pkg::REG_DISK_BLOCKS);
	assign pready = 1'b1;
	assign prdata = (paddr == slwsc_pkg::REG_DISK_BLOCKS) ?
		{{(slwsc_pkg::PDATA_W - slwsc_pkg::BC_W){1'b0}}, disk_blocks_q} : '0;

	slwsc_ram #(
		.DEPTH(SECTOR_BYTES),
		.DW(8)
	) u_line (
		.clk(clk),
		.we(ln_we),
		.waddr(ln_waddr),
		.wdata(ln_wdata),
		.raddr(ln_raddr),
		.rdata(ln_rdata)
	);

	slwsc_ram #(
		.DEPTH(DISK_BYTES),
		.DW(8)
	) u_store (
		.clk(clk),
		.we(st_we),
		.waddr(st_waddr),
		.wdata(st_wdata),
		.raddr(st_raddr),
		.rdata(st_rdata)
	);

	always_comb begin
		state_d = state_q;
		ln_we = 1'b0;
		ln_waddr = soff_q;
		ln_wdata = wdata_q;
		ln_raddr = soff_in;
		st_we = 1'b0;
		st_waddr = clr_q;
		st_wdata = '0;
		st_raddr = AW'(addr_in);
		exec_rsp = '0;
		exec_rsp.request_done = last_q;
		exec_done = 1'b0;
		wr_hit = 1'b0;
		flush_clean = 1'b0;
		out_load = 1'b0;
		out_d = res_q;
		case (state_q)
			slwsc_pkg::S_CLEAR: begin
				st_we = 1'b1;
				if (clr_q == AW'(DISK_BYTES - 1)) begin
					state_d = slwsc_pkg::S_IDLE;
				end
			end
			slwsc_pkg::S_IDLE: begin
				if (accept) begin
					state_d = slwsc_pkg::S_EXEC;
				end
			end
			slwsc_pkg::S_EXEC: begin
				case (cmd_q)
					slwsc_pkg::CMD_READ: begin
						exec_done = 1'b1;
						exec_rsp.status = oor_q;
						if (!oor_q) begin
							exec_rsp.read_data = hit_q ? ln_rdata : st_rdata;
						end
					end
					slwsc_pkg::CMD_WRITE: begin
						if (oor_q) begin
							exec_done = 1'b1;
							exec_rsp.status = 1'b1;
						end else if (hit_q) begin
							exec_done = 1'b1;
							wr_hit = 1'b1;
							ln_we = 1'b1;
						end else begin
							exec_rsp.loaded_sector = 1'b1;
							exec_rsp.wrote_back = line_valid_q && line_dirty_q;
							state_d = (line_valid_q && line_dirty_q) ?
								slwsc_pkg::S_WB : slwsc_pkg::S_LOAD;
						end
					end
					slwsc_pkg::CMD_FLUSH: begin
						if (line_valid_q && line_dirty_q) begin
							exec_rsp.wrote_back = 1'b1;
							state_d = slwsc_pkg::S_WB;
						end else begin
							exec_done = 1'b1;
							flush_clean = 1'b1;
						end
					end
					default: begin
						exec_done = 1'b1;
					end
				endcase
				if (exec_done) begin
					out_d = exec_rsp;
					if (out_free) begin
						out_load = 1'b1;
						state_d = slwsc_pkg::S_IDLE;
					end else begin
						state_d = slwsc_pkg::S_DONE;
					end
				end
			end
			slwsc_pkg::S_WB: begin
				ln_raddr = cnt_idx;
				st_waddr = AW'({line_sector_q, cnt_prev});
				st_wdata = ln_rdata;
				st_we = (cnt_q != '0);
				if (cnt_last) begin
					state_d = (cmd_q == slwsc_pkg::CMD_FLUSH) ?
						slwsc_pkg::S_DONE : slwsc_pkg::S_LOAD;
				end
			end
			slwsc_pkg::S_LOAD: begin
				st_raddr = AW'({sec_q, cnt_idx});
				ln_waddr = cnt_prev;
				ln_wdata = (cnt_prev == soff_q) ? wdata_q : st_rdata;
				ln_we = (cnt_q != '0);
				if (cnt_last) begin
					state_d = slwsc_pkg::S_DONE;
				end
			end
			slwsc_pkg::S_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d = slwsc_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = slwsc_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= slwsc_pkg::S_CLEAR;
			disk_blocks_q <= slwsc_pkg::DISK_BLOCKS_RST;
			line_valid_q <= 1'b0;
			line_dirty_q <= 1'b0;
			line_sector_q <= '0;
			cnt_q <= '0;
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				disk_blocks_q <= pwdata[slwsc_pkg::BC_W-1:0];
			end
			if (state_q == slwsc_pkg::S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (wr_hit) begin
				line_dirty_q <= 1'b1;
			end
			if (flush_clean) begin
				line_valid_q <= 1'b0;
				line_dirty_q <= 1'b0;
				line_sector_q <= '0;
			end
			if (state_q == slwsc_pkg::S_WB) begin
				if (cnt_last) begin
					cnt_q <= '0;
					line_dirty_q <= 1'b0;
					if (cmd_q == slwsc_pkg::CMD_FLUSH) begin
						line_valid_q <= 1'b0;
						line_sector_q <= '0;
					end
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (state_q == slwsc_pkg::S_LOAD) begin
				if (cnt_last) begin
					cnt_q <= '0;
					line_valid_q <= 1'b1;
					line_dirty_q <= 1'b1;
					line_sector_q <= sec_q;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// transaction and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= req.command;
			wdata_q <= req.write_data;
			last_q <= req.last_of_request;
			soff_q <= soff_in;
			sec_q <= sec_in;
			oor_q <= oor_in;
			hit_q <= hit_in;
		end
		if (state_q == slwsc_pkg::S_EXEC) begin
			res_q <= exec_rsp;
		end
		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp = out_q;

	a_clear_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == slwsc_pkg::S_CLEAR |-> req_stall)
		else $error("request taken during store clear");

	a_dirty_valid: assert property (@(posedge clk) disable iff (!arst_n)
		line_dirty_q |-> line_valid_q)
		else $error("dirty line without valid");

	a_store_write: assert property (@(posedge clk) disable iff (!arst_n)
		st_we |-> (state_q == slwsc_pkg::S_CLEAR || state_q == slwsc_pkg::S_WB))
		else $error("store written outside clear or write-back");

	a_oor_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status |->
			rsp.read_data == 8'd0 && !rsp.wrote_back && !rsp.loaded_sector)
		else $error("out of range response carries data or flags");

endmodule
